@@ rtl/itra_pkg.sv @@
// Shared constants, types and the digit-to-character function for the radix formatter.
`timescale 1ns / 1ps

package itra_pkg;

    localparam int DATA_W       = 32;
    localparam int BASE_W       = 5;
    localparam int DIGIT_W      = 4;
    localparam int CHAR_W       = 8;
    localparam int LEN_W        = 6;
    localparam int MAX_DIGITS   = 32;
    localparam int IDX_W        = $clog2(MAX_DIGITS);
    localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
    localparam int BITS_PER_CYC = 8;
    localparam int DIV_CYC      = DATA_W / BITS_PER_CYC;
    localparam int STEP_W       = $clog2(DIV_CYC);

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);
    localparam logic [BASE_W-1:0] BASE_DEC = BASE_W'(10);

    localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CH_LOWER = CHAR_W'(8'h61);
    localparam logic [CHAR_W-1:0] CH_UPPER = CHAR_W'(8'h41);
    localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(8'h2d);
    localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(9);
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);

    typedef struct packed {
        logic               done;
        logic [DATA_W-1:0]  quot;
        logic [DIGIT_W-1:0] rem;
    } t_div_res;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] ch;
        if (d > DIGIT_NINE) begin
            ch = (upper ? CH_UPPER : CH_LOWER) + CHAR_W'(d - DIGIT_TEN);
        end else begin
            ch = CH_ZERO + CHAR_W'(d);
        end
        return ch;
    endfunction

endpackage

@@ rtl/itra_divider.sv @@
// Shared divider: divides a 32-bit value by a small base, eight quotient bits per cycle.
`timescale 1ns / 1ps

module itra_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [itra_pkg::DATA_W-1:0]   i_dividend,
    input  logic [itra_pkg::BASE_W-1:0]   i_base,
    output itra_pkg::t_div_res            o_res
);
    import itra_pkg::*;

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [DATA_W-1:0]       r_quot, n_quot;
    logic [DIGIT_W-1:0]      r_rem, n_rem;
    logic [BASE_W-1:0]       r_base;

    logic [BITS_PER_CYC-1:0] qbits;
    logic [DIGIT_W-1:0]      rem_step;

    // Restoring division over the top byte of the shift register.
    always_comb begin
        logic [BASE_W-1:0] t;
        rem_step = r_rem;
        qbits    = '0;
        t        = '0;
        for (int i = 0; i < BITS_PER_CYC; i++) begin
            t = {rem_step, r_quot[DATA_W-1-i]};
            if (t >= r_base) begin
                t = t - r_base;
                qbits[BITS_PER_CYC-1-i] = 1'b1;
            end
            rem_step = t[DIGIT_W-1:0];
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_quot = r_quot;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_quot = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quot = {r_quot[DATA_W-BITS_PER_CYC-1:0], qbits};
            n_rem  = rem_step;
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(DIV_CYC - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_base <= i_base;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

@@ rtl/itra_digit_mem.sv @@
// Digit store: one write port and one registered read port.
`timescale 1ns / 1ps

module itra_digit_mem (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [itra_pkg::IDX_W-1:0]    i_waddr,
    input  logic [itra_pkg::DIGIT_W-1:0]  i_wdata,
    input  logic [itra_pkg::IDX_W-1:0]    i_raddr,
    output logic [itra_pkg::DIGIT_W-1:0]  o_rdata
);
    import itra_pkg::*;

    logic [DIGIT_W-1:0] r_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/integer_to_radix_ascii.sv @@
// Sequence: the request is loaded, each digit is produced by the shared divider, then each
// character is read from the digit store and loaded once the output register is free, a minus sign first.
// The divider retires 8 quotient bits per cycle and sets the digit rate; one request at a time.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
`timescale 1ns / 1ps

module integer_to_radix_ascii (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [31:0]                   i_value,
    input  logic [4:0]                    i_radix,
    input  logic                          i_upper_case,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_character,
    output logic                          o_last_char,
    output logic [5:0]                    o_total_length
);
    import itra_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_neg, n_neg;
    logic              r_upper, n_upper;
    logic [BASE_W-1:0] r_base, n_base;
    logic [LEN_W-1:0]  r_total, n_total;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic              r_out_last, n_out_last;
    logic [LEN_W-1:0]  r_out_len, n_out_len;

    logic              accept;
    logic              slot_free;
    logic              div_start;
    logic [DATA_W-1:0] div_operand;
    logic [BASE_W-1:0] div_base;
    logic [BASE_W-1:0] in_base;
    logic [DATA_W-1:0] in_mag;
    logic              in_neg;
    logic              mem_we;
    logic [DIGIT_W-1:0] mem_rdata;
    logic [CNT_W-1:0]  count_inc;
    t_div_res          div_res;

    assign accept    = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign slot_free = !r_out_valid || i_ready;
    assign count_inc = r_count + CNT_W'(1);

    always_comb begin
        in_neg  = 1'b0;
        in_mag  = i_value;
        in_base = BASE_DEC;
        if (!i_func) begin
            if (i_value[DATA_W-1]) begin
                in_neg = 1'b1;
                in_mag = DATA_W'(0) - i_value;
            end
        end else if (i_radix < BASE_MIN) begin
            in_base = BASE_MIN;
        end else if (i_radix > BASE_MAX) begin
            in_base = BASE_MAX;
        end else begin
            in_base = i_radix;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_neg       = r_neg;
        n_upper     = r_upper;
        n_base      = r_base;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_len   = r_out_len;
        div_start   = 1'b0;
        div_operand = in_mag;
        div_base    = r_base;
        mem_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    div_start = 1'b1;
                    div_base  = in_base;
                    n_base    = in_base;
                    n_neg     = in_neg;
                    n_upper   = i_upper_case;
                    n_count   = '0;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    mem_we  = 1'b1;
                    n_count = count_inc;
                    if (div_res.quot != '0 && count_inc < CNT_W'(MAX_DIGITS)) begin
                        div_start   = 1'b1;
                        div_operand = div_res.quot;
                    end else begin
                        n_idx   = count_inc;
                        n_total = LEN_W'({1'b0, count_inc} + (CNT_W + 1)'(r_neg));
                        n_state = r_neg ? S_SIGN : S_READ;
                    end
                end
            end
            S_SIGN: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_MINUS;
                    n_out_last  = 1'b0;
                    n_out_len   = r_total;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = digit_char(mem_rdata, r_upper);
                    n_out_last  = (r_idx == CNT_W'(1));
                    n_out_len   = r_total;
                    n_idx       = r_idx - CNT_W'(1);
                    n_state     = (r_idx == CNT_W'(1)) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx      <= n_idx;
        r_neg      <= n_neg;
        r_upper    <= n_upper;
        r_base     <= n_base;
        r_total    <= n_total;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_len  <= n_out_len;
    end

    itra_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_operand),
        .i_base     (div_base),
        .o_res      (div_res)
    );

    // Digits are written least significant first and read back from the top.
    itra_digit_mem u_digit_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (div_res.rem),
        .i_raddr (IDX_W'(r_idx - CNT_W'(1))),
        .o_rdata (mem_rdata)
    );

    assign o_valid        = r_out_valid;
    assign o_character    = r_out_char;
    assign o_last_char    = r_out_last;
    assign o_total_length = r_out_len;

endmodule
